/* hw/rtl/padc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// padc_pkg: shared types and constants for the parallel ADC read sequencer
// Holds the sequencer phases, request codes, the timer control bundle, the
// result record and the helper functions used by the pin sequencer.
// ----------------------------------------------------------------------------
package padc_pkg;

  // Number of channels visited by a scan request.
  localparam int NUM_CHANNELS = 8;

  // Field widths.
  localparam int TPU_W   = 10;  // ticks per microsecond
  localparam int MS_W    = 4;   // millisecond registers
  localparam int US_W    = 14;  // microsecond count, up to 15 ms
  localparam int CH_W    = 3;
  localparam int SLOT_W  = 4;
  localparam int WORD_W  = 16;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [US_W-1:0]   US_PER_MS = US_W'(1000);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(15);

  // Request kinds carried by each input beat.
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INIT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SCAN   = 2'd3;

  // Request mode latched at the start of a read.
  localparam logic [1:0] MODE_SINGLE = 2'd2;
  localparam logic [1:0] MODE_SCAN   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_HOLD_MS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_SETTLE_MS = 2'd2;

  // Sequencer phases.
  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_RST_HOLD   = 4'd1,
    PH_RST_SETTLE = 4'd2,
    PH_SEL        = 4'd3,
    PH_CV1        = 4'd4,
    PH_BW1        = 4'd5,
    PH_CV2        = 4'd6,
    PH_BW2        = 4'd7,
    PH_RDA        = 4'd8,
    PH_GAP        = 4'd9,
    PH_RDB        = 4'd10
  } phase_t;

  // Control from the sequencer to the delay timer.
  typedef struct packed {
    logic            load;     // start a new timed phase
    logic            tick;     // count one tick of the current phase
    logic [US_W-1:0] load_us;  // length of the new phase in microseconds
  } tmr_ctrl_t;

  // One result beat.
  typedef struct packed {
    logic [CH_W-1:0]          chan_select;
    logic                     convst;
    logic                     cs_n;
    logic                     rd_n;
    logic                     reset_n;
    logic                     ready_res;
    logic                     sample_valid;
    logic signed [WORD_W-1:0] sample_value;
    logic [SLOT_W-1:0]        sample_index;
    logic                     scan_done;
  } res_t;

  // Milliseconds to microseconds; a zero setting lasts one microsecond.
  function automatic logic [US_W-1:0] ms_to_us(input logic [MS_W-1:0] ms);
    logic [US_W-1:0] us;
    us = US_W'(ms) * US_PER_MS;
    if (ms == '0) begin
      us = US_W'(1);
    end
    return us;
  endfunction

  // Reverse the bit order inside each byte of a word.
  function automatic logic [WORD_W-1:0] byte_reverse(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i]  = v[i];
      r[15 - i] = v[8 + i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/parallel_adc_read_sequencer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// parallel_adc_read_sequencer: tick-driven controller for a parallel ADC
// Sequences reset, convert-start, busy waits and dual-word reads, and
// reports pin levels and captured samples once per tick.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one tick per beat: a
//   request kind, a channel, the busy pin level and the raw data bus.
//   Every accepted beat yields exactly one result beat on the output
//   channel (out_valid / out_stall) with the pin levels of that tick and,
//   when a word is captured, its value with each byte bit-reversed and slot.
//   A result beat appears in the cycle after its tick is accepted; one
//   beat is taken every cycle while the result channel is not stalled, and
//   the sequencer state, delay timer and result register update then.
//   When the receiver stalls, the result register holds its beat and
//   in_stall rises, so no tick is taken until the beat leaves.
//   Reset clears the sequencer to idle, empties the result register and
//   loads the configuration registers with their defaults (170 ticks per
//   microsecond, 1 ms reset hold, 4 ms settle). Configuration writes on
//   cfg_we / cfg_index / cfg_data belong to idle periods only.
// ----------------------------------------------------------------------------
module parallel_adc_read_sequencer (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Configuration writes.
  input  wire logic                               cfg_we,
  input  wire logic [padc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [padc_pkg::TPU_W-1:0]         cfg_data,
  // Input tick channel.
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire logic [padc_pkg::KIND_W-1:0]        kind,
  input  wire logic [padc_pkg::CH_W-1:0]          channel,
  input  wire logic                               busy_req,
  input  wire logic [padc_pkg::WORD_W-1:0]        data_bus,
  // Result channel.
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      logic [padc_pkg::CH_W-1:0]          chan_select,
  output      logic                               convst,
  output      logic                               cs_n,
  output      logic                               rd_n,
  output      logic                               reset_n,
  output      logic                               ready_res,
  output      logic                               sample_valid,
  output      logic signed [padc_pkg::WORD_W-1:0] sample_value,
  output      logic [padc_pkg::SLOT_W-1:0]        sample_index,
  output      logic                               scan_done
);

  logic [padc_pkg::TPU_W-1:0] ticks_per_us;
  logic [padc_pkg::MS_W-1:0]  reset_hold_ms;
  logic [padc_pkg::MS_W-1:0]  reset_settle_ms;
  logic                       accept;
  logic                       tmr_done;
  padc_pkg::tmr_ctrl_t        tmr_ctrl;
  padc_pkg::res_t             res;
  padc_pkg::res_t             res_q;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us    <= padc_pkg::TPU_W'(170);
      reset_hold_ms   <= padc_pkg::MS_W'(1);
      reset_settle_ms <= padc_pkg::MS_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_index)
        padc_pkg::CFG_TICKS_PER_US:    ticks_per_us    <= cfg_data;
        padc_pkg::CFG_RESET_HOLD_MS:   reset_hold_ms   <= cfg_data[padc_pkg::MS_W-1:0];
        padc_pkg::CFG_RESET_SETTLE_MS: reset_settle_ms <= cfg_data[padc_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  // A tick is taken whenever the result register can move.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  padc_timer u_timer (
    .clk          (clk),
    .rst          (rst),
    .ticks_per_us (ticks_per_us),
    .ctrl         (tmr_ctrl),
    .done         (tmr_done)
  );

  padc_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .kind            (kind),
    .channel         (channel),
    .busy_req        (busy_req),
    .data_bus        (data_bus),
    .reset_hold_ms   (reset_hold_ms),
    .reset_settle_ms (reset_settle_ms),
    .tmr_done        (tmr_done),
    .tmr_ctrl        (tmr_ctrl),
    .res             (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign chan_select  = res_q.chan_select;
  assign convst       = res_q.convst;
  assign cs_n         = res_q.cs_n;
  assign rd_n         = res_q.rd_n;
  assign reset_n      = res_q.reset_n;
  assign ready_res    = res_q.ready_res;
  assign sample_valid = res_q.sample_valid;
  assign sample_value = res_q.sample_value;
  assign sample_index = res_q.sample_index;
  assign scan_done    = res_q.scan_done;

  // A captured word always comes from a tick with the read strobe low.
  a_sample_on_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_valid |-> !rd_n && !cs_n && !convst)
    else $error("sample presented outside a read strobe");

  // The end-of-request mark only rides on a sample.
  a_done_with_sample: assert property (@(posedge clk) disable iff (rst)
    out_valid && scan_done |-> sample_valid)
    else $error("scan_done without a sample");

  // While ready, the ADC pins rest in their idle levels.
  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    out_valid && ready_res |-> !convst && cs_n && rd_n && reset_n && !sample_valid)
    else $error("pins active while ready");

  // A stalled result beat stays in place until it is taken.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res_q))
    else $error("stalled result beat changed");

endmodule
`default_nettype wire

/* hw/rtl/padc_timer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// padc_timer: microsecond delay timer
// Counts ticks within a microsecond and microseconds within a timed phase.
// Reports done on the last tick of the phase.
// ----------------------------------------------------------------------------
module padc_timer (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [padc_pkg::TPU_W-1:0]   ticks_per_us,
  input  wire padc_pkg::tmr_ctrl_t          ctrl,
  output      logic                         done
);

  logic [padc_pkg::TPU_W-1:0] delay_count;
  logic [padc_pkg::US_W-1:0]  us_left;
  logic [padc_pkg::TPU_W-1:0] reload;

  // A zero tick setting behaves as one tick per microsecond.
  assign reload = (ticks_per_us == '0) ? padc_pkg::TPU_W'(1) : ticks_per_us;

  assign done = (delay_count <= padc_pkg::TPU_W'(1)) &&
                (us_left <= padc_pkg::US_W'(1));

  // Load a new phase, or step the tick and microsecond counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_count <= '0;
      us_left     <= '0;
    end else if (ctrl.load) begin
      delay_count <= reload;
      us_left     <= ctrl.load_us;
    end else if (ctrl.tick && !done) begin
      if (delay_count > padc_pkg::TPU_W'(1)) begin
        delay_count <= delay_count - padc_pkg::TPU_W'(1);
      end else begin
        delay_count <= reload;
        us_left     <= us_left - padc_pkg::US_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/padc_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// padc_seq: ADC pin sequencer
// Walks the init and read phases, drives the pin levels and captures
// sample words from the data bus. State advances on each accepted beat.
// ----------------------------------------------------------------------------
module padc_seq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic [padc_pkg::KIND_W-1:0]   kind,
  input  wire logic [padc_pkg::CH_W-1:0]     channel,
  input  wire logic                          busy_req,
  input  wire logic [padc_pkg::WORD_W-1:0]   data_bus,
  input  wire logic [padc_pkg::MS_W-1:0]     reset_hold_ms,
  input  wire logic [padc_pkg::MS_W-1:0]     reset_settle_ms,
  input  wire logic                          tmr_done,
  output      padc_pkg::tmr_ctrl_t           tmr_ctrl,
  output      padc_pkg::res_t                res
);

  padc_pkg::phase_t          phase, phase_next;
  logic [padc_pkg::CH_W-1:0] scan_channel, scan_channel_next;
  logic [1:0]                request_mode, request_mode_next;
  logic [padc_pkg::CH_W-1:0] select_latch, select_latch_next;
  logic                      timed;
  logic                      is_scan;
  logic                      last_chan;

  assign is_scan   = (request_mode == padc_pkg::MODE_SCAN);
  assign last_chan = (int'(scan_channel) + 1) >= padc_pkg::NUM_CHANNELS;

  // Next state of the sequencer.
  always_comb begin
    phase_next        = phase;
    scan_channel_next = scan_channel;
    request_mode_next = request_mode;
    select_latch_next = select_latch;
    unique case (phase)
      padc_pkg::PH_RST_HOLD: begin
        if (tmr_done) begin
          select_latch_next = '0;
          phase_next        = padc_pkg::PH_RST_SETTLE;
        end
      end
      padc_pkg::PH_RST_SETTLE: if (tmr_done) phase_next = padc_pkg::PH_IDLE;
      padc_pkg::PH_SEL:        if (tmr_done) phase_next = padc_pkg::PH_CV1;
      padc_pkg::PH_CV1:        if (tmr_done) phase_next = padc_pkg::PH_BW1;
      padc_pkg::PH_BW1:        if (!busy_req) phase_next = padc_pkg::PH_CV2;
      padc_pkg::PH_CV2:        if (tmr_done) phase_next = padc_pkg::PH_BW2;
      padc_pkg::PH_BW2:        if (!busy_req) phase_next = padc_pkg::PH_RDA;
      padc_pkg::PH_RDA:        if (tmr_done) phase_next = padc_pkg::PH_GAP;
      padc_pkg::PH_GAP:        if (tmr_done) phase_next = padc_pkg::PH_RDB;
      padc_pkg::PH_RDB: begin
        if (tmr_done) begin
          if (is_scan && !last_chan) begin
            scan_channel_next = scan_channel + padc_pkg::CH_W'(1);
            select_latch_next = scan_channel + padc_pkg::CH_W'(1);
            phase_next        = padc_pkg::PH_SEL;
          end else begin
            phase_next = padc_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        // Idle, and any unused phase code, takes a new request.
        phase_next = padc_pkg::PH_IDLE;
        unique case (kind)
          padc_pkg::KIND_INIT: phase_next = padc_pkg::PH_RST_HOLD;
          padc_pkg::KIND_SINGLE: begin
            request_mode_next = padc_pkg::MODE_SINGLE;
            scan_channel_next = '0;
            select_latch_next = channel;
            phase_next        = padc_pkg::PH_SEL;
          end
          padc_pkg::KIND_SCAN: begin
            request_mode_next = padc_pkg::MODE_SCAN;
            scan_channel_next = '0;
            select_latch_next = '0;
            phase_next        = padc_pkg::PH_SEL;
          end
          default: ;
        endcase
      end
    endcase
  end

  // Pin levels, sample capture and timer control.
  always_comb begin
    res              = '0;
    res.chan_select  = select_latch;
    res.cs_n         = 1'b1;
    res.rd_n         = 1'b1;
    res.reset_n      = 1'b1;
    timed            = 1'b1;
    tmr_ctrl.load    = 1'b0;
    tmr_ctrl.load_us = padc_pkg::US_W'(1);
    unique case (phase)
      padc_pkg::PH_RST_HOLD: begin
        res.reset_n = 1'b0;
        if (tmr_done) begin
          tmr_ctrl.load    = 1'b1;
          tmr_ctrl.load_us = padc_pkg::ms_to_us(reset_settle_ms);
        end
      end
      padc_pkg::PH_RST_SETTLE: res.chan_select = '0;
      padc_pkg::PH_SEL: tmr_ctrl.load = tmr_done;
      padc_pkg::PH_CV1, padc_pkg::PH_CV2: res.convst = 1'b1;
      padc_pkg::PH_BW1, padc_pkg::PH_BW2: begin
        timed         = 1'b0;
        tmr_ctrl.load = !busy_req;
      end
      padc_pkg::PH_RDA: begin
        res.cs_n = 1'b0;
        res.rd_n = 1'b0;
        if (tmr_done) begin
          tmr_ctrl.load    = 1'b1;
          res.sample_valid = 1'b1;
          res.sample_value = padc_pkg::byte_reverse(data_bus);
          if (is_scan) begin
            res.sample_index = padc_pkg::SLOT_W'(scan_channel);
          end else begin
            res.sample_index = padc_pkg::SLOT_W'(select_latch);
            res.scan_done    = 1'b1;
          end
        end
      end
      padc_pkg::PH_GAP: begin
        res.cs_n      = 1'b0;
        tmr_ctrl.load = tmr_done;
      end
      padc_pkg::PH_RDB: begin
        res.cs_n = 1'b0;
        res.rd_n = 1'b0;
        if (tmr_done && is_scan) begin
          res.sample_valid = 1'b1;
          res.sample_value = padc_pkg::byte_reverse(data_bus);
          res.sample_index = padc_pkg::SLOT_LAST - padc_pkg::SLOT_W'(scan_channel);
          res.scan_done    = last_chan;
          tmr_ctrl.load    = !last_chan;
        end
      end
      default: begin
        res.ready_res = 1'b1;
        timed         = 1'b0;
        unique case (kind)
          padc_pkg::KIND_INIT: begin
            tmr_ctrl.load    = 1'b1;
            tmr_ctrl.load_us = padc_pkg::ms_to_us(reset_hold_ms);
          end
          padc_pkg::KIND_SINGLE, padc_pkg::KIND_SCAN: tmr_ctrl.load = 1'b1;
          default: ;
        endcase
      end
    endcase
    // Nothing moves unless a beat is accepted.
    tmr_ctrl.load = tmr_ctrl.load && accept;
    tmr_ctrl.tick = timed && accept;
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= padc_pkg::PH_IDLE;
      scan_channel <= '0;
      request_mode <= '0;
      select_latch <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      scan_channel <= scan_channel_next;
      request_mode <= request_mode_next;
      select_latch <= select_latch_next;
    end
  end

endmodule
`default_nettype wire

/* bench/adc_seq_checker.sv */
// ----------------------------------------------------------------------------
// adc_seq_checker: result checker for the parallel ADC read sequencer
// Watches the tick and result channels and the configuration port. It keeps
// its own copy of the sequencer and its timers, predicts the pin levels and
// any captured sample for every accepted tick, and compares each result beat
// against the oldest prediction.
// ----------------------------------------------------------------------------
module adc_seq_checker
  import padc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [TPU_W-1:0]         cfg_data,
  input  wire logic                     in_valid,
  input  wire logic                     in_stall,
  input  wire logic [KIND_W-1:0]        kind,
  input  wire logic [CH_W-1:0]          channel,
  input  wire logic                     busy_req,
  input  wire logic [WORD_W-1:0]        data_bus,
  input  wire logic                     out_valid,
  input  wire logic                     out_stall,
  input  wire logic [CH_W-1:0]          chan_select,
  input  wire logic                     convst,
  input  wire logic                     cs_n,
  input  wire logic                     rd_n,
  input  wire logic                     reset_n,
  input  wire logic                     ready_res,
  input  wire logic                     sample_valid,
  input  wire logic signed [WORD_W-1:0] sample_value,
  input  wire logic [SLOT_W-1:0]        sample_index,
  input  wire logic                     scan_done,
  output int                            fail_count,
  output int                            pending,
  output logic                          seq_idle
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow configuration.
  logic [TPU_W-1:0] cfg_tpu;
  logic [MS_W-1:0]  cfg_hold;
  logic [MS_W-1:0]  cfg_settle;

  // Shadow sequencer state.
  phase_t           seq_phase;
  logic [TPU_W-1:0] tick_left;
  logic [US_W-1:0]  us_remaining;
  logic [CH_W-1:0]  scan_ch;
  logic [1:0]       req_mode;
  logic [CH_W-1:0]  sel_ch;

  // Pin and sample predictions waiting for their result beat.
  res_t predicted_pins[$];
  int   result_no;

  task automatic report_error(input string msg);
    $display("%0t: MISMATCH %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want) begin
      report_error($sformatf("result %0d: %s is %0d, expected %0d",
                             result_no, name, got, want));
    end
  endtask

  // A zero tick setting still takes one tick per microsecond.
  function automatic logic [TPU_W-1:0] reload_ticks();
    return (cfg_tpu == '0) ? TPU_W'(1) : cfg_tpu;
  endfunction

  // A zero millisecond setting lasts a single microsecond.
  function automatic logic [US_W-1:0] ms_as_us(input logic [MS_W-1:0] ms);
    return (ms == '0) ? US_W'(1) : US_W'(ms) * US_W'(1000);
  endfunction

  function automatic logic [WORD_W-1:0] mirror_bytes(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] m;
    for (int b = 0; b < 8; b++) begin
      m[b]     = w[7 - b];
      m[8 + b] = w[15 - b];
    end
    return m;
  endfunction

  task automatic start_phase(input phase_t p, input logic [US_W-1:0] us);
    seq_phase    = p;
    us_remaining = (us == '0) ? US_W'(1) : us;
    tick_left    = reload_ticks();
  endtask

  // Counts one tick of a timed phase; true once the whole phase has run.
  function automatic bit phase_elapsed();
    if (tick_left > 1) begin
      tick_left--;
      return 1'b0;
    end
    if (us_remaining > 1) begin
      us_remaining--;
      tick_left = reload_ticks();
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advances the shadow sequencer by one tick and returns its result beat.
  task automatic predict_tick(input logic [KIND_W-1:0] k, input logic [CH_W-1:0] ch,
                              input logic busy, input logic [WORD_W-1:0] bus,
                              output res_t r);
    bit last;
    r = '0;
    r.chan_select = sel_ch;
    r.cs_n        = 1'b1;
    r.rd_n        = 1'b1;
    r.reset_n     = 1'b1;

    // Pin levels come from the phase held at the start of the tick.
    case (seq_phase)
      PH_RST_HOLD:   r.reset_n = 1'b0;
      PH_RST_SETTLE: r.chan_select = '0;
      PH_CV1, PH_CV2: r.convst = 1'b1;
      PH_RDA, PH_RDB: begin
        r.cs_n = 1'b0;
        r.rd_n = 1'b0;
      end
      PH_GAP:        r.cs_n = 1'b0;
      PH_SEL, PH_BW1, PH_BW2: ;
      default:       r.ready_res = 1'b1;
    endcase

    // Phase transitions.
    case (seq_phase)
      PH_RST_HOLD: begin
        if (phase_elapsed()) begin
          sel_ch = '0;
          start_phase(PH_RST_SETTLE, ms_as_us(cfg_settle));
        end
      end
      PH_RST_SETTLE: begin
        if (phase_elapsed()) seq_phase = PH_IDLE;
      end
      PH_SEL: begin
        if (phase_elapsed()) start_phase(PH_CV1, US_W'(1));
      end
      PH_CV1: begin
        if (phase_elapsed()) seq_phase = PH_BW1;
      end
      PH_BW1: begin
        if (!busy) start_phase(PH_CV2, US_W'(1));
      end
      PH_CV2: begin
        if (phase_elapsed()) seq_phase = PH_BW2;
      end
      PH_BW2: begin
        if (!busy) start_phase(PH_RDA, US_W'(1));
      end
      PH_RDA: begin
        if (phase_elapsed()) begin
          r.sample_valid = 1'b1;
          r.sample_value = mirror_bytes(bus);
          if (req_mode == MODE_SCAN) begin
            r.sample_index = {1'b0, scan_ch};
          end else begin
            r.sample_index = {1'b0, sel_ch};
            r.scan_done    = 1'b1;
          end
          start_phase(PH_GAP, US_W'(1));
        end
      end
      PH_GAP: begin
        if (phase_elapsed()) start_phase(PH_RDB, US_W'(1));
      end
      PH_RDB: begin
        if (phase_elapsed()) begin
          if (req_mode == MODE_SCAN) begin
            // Word B of a scan lands in the mirrored slot.
            last           = (int'(scan_ch) + 1) >= NUM_CHANNELS;
            r.sample_valid = 1'b1;
            r.sample_value = mirror_bytes(bus);
            r.sample_index = SLOT_LAST - {1'b0, scan_ch};
            r.scan_done    = last;
            if (!last) begin
              scan_ch = scan_ch + 1'b1;
              sel_ch  = scan_ch;
              start_phase(PH_SEL, US_W'(1));
            end else begin
              seq_phase = PH_IDLE;
            end
          end else begin
            // A single read drops word B.
            seq_phase = PH_IDLE;
          end
        end
      end
      default: begin
        seq_phase = PH_IDLE;
        case (k)
          KIND_INIT: start_phase(PH_RST_HOLD, ms_as_us(cfg_hold));
          KIND_SINGLE: begin
            req_mode = MODE_SINGLE;
            scan_ch  = '0;
            sel_ch   = ch;
            start_phase(PH_SEL, US_W'(1));
          end
          KIND_SCAN: begin
            req_mode = MODE_SCAN;
            scan_ch  = '0;
            sel_ch   = '0;
            start_phase(PH_SEL, US_W'(1));
          end
          default: ;
        endcase
      end
    endcase
  endtask

  // Predict on every accepted tick, then compare every accepted result beat.
  always @(posedge clk) begin : watch
    res_t want;
    res_t got;
    if (rst) begin
      cfg_tpu      = TPU_W'(170);
      cfg_hold     = MS_W'(1);
      cfg_settle   = MS_W'(4);
      seq_phase    = PH_IDLE;
      tick_left    = '0;
      us_remaining = '0;
      scan_ch      = '0;
      req_mode     = '0;
      sel_ch       = '0;
      predicted_pins.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TICKS_PER_US:    cfg_tpu = cfg_data;
          CFG_RESET_HOLD_MS:   cfg_hold = cfg_data[MS_W-1:0];
          CFG_RESET_SETTLE_MS: cfg_settle = cfg_data[MS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_tick(kind, channel, busy_req, data_bus, want);
        predicted_pins.push_back(want);
      end
      if (out_valid && !out_stall) begin
        result_no++;
        got.chan_select  = chan_select;
        got.convst       = convst;
        got.cs_n         = cs_n;
        got.rd_n         = rd_n;
        got.reset_n      = reset_n;
        got.ready_res    = ready_res;
        got.sample_valid = sample_valid;
        got.sample_value = sample_value;
        got.sample_index = sample_index;
        got.scan_done    = scan_done;
        if (predicted_pins.size() == 0) begin
          report_error($sformatf("result %0d arrived with no tick waiting", result_no));
        end else begin
          want = predicted_pins.pop_front();
          check_field("chan_select", got.chan_select, want.chan_select);
          check_field("convst", got.convst, want.convst);
          check_field("cs_n", got.cs_n, want.cs_n);
          check_field("rd_n", got.rd_n, want.rd_n);
          check_field("reset_n", got.reset_n, want.reset_n);
          check_field("ready_res", got.ready_res, want.ready_res);
          check_field("sample_valid", got.sample_valid, want.sample_valid);
          check_field("sample_value", got.sample_value, want.sample_value);
          check_field("sample_index", got.sample_index, want.sample_index);
          check_field("scan_done", got.scan_done, want.scan_done);
        end
      end
    end
    pending  <= predicted_pins.size();
    seq_idle <= (seq_phase == PH_IDLE);
  end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the parallel ADC read sequencer
// Drives ticks with random busy levels and data words, first through a
// directed list of requests and register settings, then through random
// request mixes at several timer settings. Random gaps on the tick channel
// and random stalls on the result channel; the checker does the comparing.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import padc_pkg::*;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
  localparam int                   QUIET_LIMIT = 5000;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [TPU_W-1:0]         cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [KIND_W-1:0]        kind;
  logic [CH_W-1:0]          channel;
  logic                     busy_req;
  logic [WORD_W-1:0]        data_bus;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [CH_W-1:0]          chan_select;
  logic                     convst;
  logic                     cs_n;
  logic                     rd_n;
  logic                     reset_n;
  logic                     ready_res;
  logic                     sample_valid;
  logic signed [WORD_W-1:0] sample_value;
  logic [SLOT_W-1:0]        sample_index;
  logic                     scan_done;

  int   fail_count;
  int   pending;
  logic seq_idle;

  // Stimulus knobs: busy level odds and a stretch with no gaps or stalls.
  int busy_pct;
  bit calm = 1'b0;

  parallel_adc_read_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .channel      (channel),
    .busy_req     (busy_req),
    .data_bus     (data_bus),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .chan_select  (chan_select),
    .convst       (convst),
    .cs_n         (cs_n),
    .rd_n         (rd_n),
    .reset_n      (reset_n),
    .ready_res    (ready_res),
    .sample_valid (sample_valid),
    .sample_value (sample_value),
    .sample_index (sample_index),
    .scan_done    (scan_done)
  );

  adc_seq_checker pin_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .channel      (channel),
    .busy_req     (busy_req),
    .data_bus     (data_bus),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .chan_select  (chan_select),
    .convst       (convst),
    .cs_n         (cs_n),
    .rd_n         (rd_n),
    .reset_n      (reset_n),
    .ready_res    (ready_res),
    .sample_valid (sample_valid),
    .sample_value (sample_value),
    .sample_index (sample_index),
    .scan_done    (scan_done),
    .fail_count   (fail_count),
    .pending      (pending),
    .seq_idle     (seq_idle)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls now and then, except in the calm stretch.
  always @(posedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(99) < 6);
  end

  // Data words lean toward corner patterns.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(11))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h0001;
      4: return 16'h00FF;
      5: return 16'hFF00;
      6: return 16'h7FFE;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // Sends one tick beat, sometimes after a one-cycle gap.
  task automatic drive_tick(input logic [KIND_W-1:0] k, input logic [CH_W-1:0] ch);
    if (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    channel  <= ch;
    busy_req <= ($urandom_range(99) < busy_pct);
    data_bus <= pick_word();
    do @(posedge clk); while (in_stall);
  endtask

  task automatic plain_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      drive_tick(KIND_TICK, CH_W'($urandom));
    end
  endtask

  // Plain ticks until the sequencer is back in idle.
  task automatic wait_idle();
    do drive_tick(KIND_TICK, CH_W'($urandom)); while (!seq_idle);
  endtask

  // Stops sending and lets every outstanding result drain.
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  // Writes all three registers, plus the unused index with random data.
  task automatic set_config(input logic [TPU_W-1:0] tpu, input logic [MS_W-1:0] hold_ms,
                            input logic [MS_W-1:0] settle_ms);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TICKS_PER_US;
    cfg_data  <= tpu;
    @(posedge clk);
    cfg_index <= CFG_RESET_HOLD_MS;
    cfg_data  <= {6'($urandom), hold_ms};
    @(posedge clk);
    cfg_index <= CFG_RESET_SETTLE_MS;
    cfg_data  <= {6'($urandom), settle_ms};
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data  <= TPU_W'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly plain ticks that let requests run, mixed with new requests.
  task automatic random_ticks(input int n);
    int roll;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        quiesce();
      end
      roll = $urandom_range(99);
      if (roll < 78) begin
        drive_tick(KIND_TICK, CH_W'($urandom));
      end else if (roll < 83) begin
        drive_tick(KIND_INIT, CH_W'($urandom));
      end else if (roll < 91) begin
        drive_tick(KIND_SINGLE, CH_W'($urandom));
      end else begin
        drive_tick(KIND_SCAN, CH_W'($urandom));
      end
    end
  endtask

  // Ends the run when no beat has moved on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    kind      = KIND_TICK;
    channel   = '0;
    busy_req  = 1'b0;
    data_bus  = '0;
    busy_pct  = 30;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Before any init the block is ready with reset_n high; start a read at
    // the default tick setting.
    plain_ticks(3);
    drive_tick(KIND_SINGLE, 3'd5);
    plain_ticks(40);

    // A new tick setting mid-phase applies from the next microsecond reload.
    quiesce();
    set_config(10'd1, 4'd0, 4'd0);
    wait_idle();

    // Zero tick and millisecond settings shrink every timed phase to one tick.
    quiesce();
    set_config(10'd0, 4'd0, 4'd0);
    drive_tick(KIND_INIT, 3'd0);
    wait_idle();
    drive_tick(KIND_SINGLE, 3'd0);
    wait_idle();
    drive_tick(KIND_SINGLE, 3'd7);
    wait_idle();
    drive_tick(KIND_SCAN, 3'd0);
    wait_idle();

    // Requests that arrive while a read is running are ignored.
    drive_tick(KIND_SINGLE, 3'd2);
    drive_tick(KIND_SCAN, 3'd5);
    drive_tick(KIND_INIT, 3'd1);
    drive_tick(KIND_SINGLE, 3'd6);
    wait_idle();

    // Busy held high keeps the sequencer waiting with no timeout.
    drive_tick(KIND_SCAN, 3'd3);
    busy_pct = 100;
    plain_ticks(100);
    busy_pct = 30;
    wait_idle();

    // A longer microsecond.
    quiesce();
    set_config(10'd20, 4'd0, 4'd0);
    drive_tick(KIND_SINGLE, 3'd4);
    wait_idle();

    // Random request mixes at a few timer settings.
    quiesce();
    set_config(10'd1, 4'd0, 4'd0);
    random_ticks(175);
    wait_idle();
    quiesce();
    calm <= 1'b1;
    set_config(10'd2, 4'd0, 4'd0);
    random_ticks(175);
    wait_idle();
    quiesce();
    calm <= 1'b0;
    busy_pct = 60;
    set_config(10'd0, 4'd0, 4'd0);
    random_ticks(175);
    wait_idle();
    quiesce();
    busy_pct = 15;
    set_config(10'd3, 4'd0, 4'd0);
    random_ticks(175);

    // Drain and give the verdict.
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
